>>> hdl/gsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gsc_pkg;

   localparam int SAMPLES_PER_TICK_DEF = 10;
   localparam int QUEUE_DEPTH_DEF      = 4;

   localparam int NUM_AXES = 3;
   localparam int RATE_W   = 16;
   // 15 full-scale samples fit; bounds the SAMPLES_PER_TICK range
   localparam int SUM_W    = 20;
   localparam int AVG_W    = 16;
   localparam int WEIGHT_W = 8;
   localparam int COUNT_W  = 8;
   localparam int STEPS_W  = 16;

   localparam int CSR_W       = 16;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_CHANGE,
      CSR_MAX_CHANGE,
      CSR_AXIS_PERIOD,
      CSR_WINDOW_TICKS
   } csr_index_type;

   localparam logic [15:0]        MIN_CHANGE_RST   = 16'd200;
   localparam logic [15:0]        MAX_CHANGE_RST   = 16'd5000;
   localparam logic [COUNT_W-1:0] AXIS_PERIOD_RST  = 8'd30;
   localparam logic [COUNT_W-1:0] WINDOW_TICKS_RST = 8'd6;

   typedef enum logic [1:0] {
      AXIS_NONE,
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
      logic signed [RATE_W-1:0] rate_z;
   } req_type;

   typedef struct packed {
      logic [STEPS_W-1:0] step_total;
      logic [1:0]         dominant_axis;
      logic               crossed_now;
      logic               step_added;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        min_change;
      logic [15:0]        max_change;
      logic [COUNT_W-1:0] axis_period;
      logic [COUNT_W-1:0] window_ticks;
   } cfg_type;

   typedef logic [NUM_AXES-1:0][SUM_W-1:0] sums_type;

endpackage
`default_nettype wire

>>> hdl/gyro_step_counter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Gyro step counter. Its front accumulator takes one three-axis gyro sample per
// cycle while req_full is low, and one result word is emitted every
// SAMPLES_PER_TICK samples. The back end pipeline (reciprocal multiply, sign
// restore, tick update, midpoint crossing, window close) retires one tick per
// cycle while the result queue is not full, so the sustained rate is one sample
// per clock for any SAMPLES_PER_TICK. Results reach rsp_ through the tick
// queue, back-end registers and result queue. Input stalls (req_full) only when
// the result queue is full and the tick queue behind it has filled.
// Configuration registers are written through csr_write/csr_index/csr_wdata;
// the user must do so only while the block is idle; this is not enforced.
module gyro_step_counter_core #(
   parameter int SAMPLES_PER_TICK = gsc_pkg::SAMPLES_PER_TICK_DEF,
   parameter int QUEUE_DEPTH      = gsc_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   input  wire gsc_pkg::req_type                  req_word,
   output logic                                   req_full,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output gsc_pkg::rsp_type                       rsp_word,
   input  wire logic                              csr_write,
   input  wire logic [gsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [gsc_pkg::CSR_W-1:0]         csr_wdata
);
   import gsc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     sums_push, sums_full, sums_empty, sums_pop;
   sums_type sums_in_word, sums_out_word;
   logic     back_push, back_full;
   rsp_type  back_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_CHANGE:   cfg_in.min_change   = csr_wdata;
            CSR_MAX_CHANGE:   cfg_in.max_change   = csr_wdata;
            CSR_AXIS_PERIOD:  cfg_in.axis_period  = csr_wdata[COUNT_W-1:0];
            CSR_WINDOW_TICKS: cfg_in.window_ticks = csr_wdata[COUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_change   <= MIN_CHANGE_RST;
         cfg_ff.max_change   <= MAX_CHANGE_RST;
         cfg_ff.axis_period  <= AXIS_PERIOD_RST;
         cfg_ff.window_ticks <= WINDOW_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gsc_front #(
      .SAMPLES_PER_TICK(SAMPLES_PER_TICK)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .sums_push (sums_push),
      .sums_word (sums_in_word),
      .sums_full (sums_full)
   );

   gsc_fifo #(
      .word_type (sums_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_tick_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (sums_push),
      .push_word (sums_in_word),
      .full      (sums_full),
      .empty     (sums_empty),
      .pop       (sums_pop),
      .pop_word  (sums_out_word)
   );

   gsc_back #(
      .SAMPLES_PER_TICK(SAMPLES_PER_TICK)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .sums_empty (sums_empty),
      .sums_pop   (sums_pop),
      .sums_word  (sums_out_word),
      .rsp_push   (back_push),
      .rsp_word   (back_word),
      .rsp_full   (back_full)
   );

   gsc_fifo #(
      .word_type (rsp_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_word (back_word),
      .full      (back_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_word  (rsp_word)
   );

endmodule
`default_nettype wire

>>> hdl/gsc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module gsc_fifo #(
   parameter type word_type = logic,
   parameter int  DEPTH     = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire word_type push_word,
   output logic          full,
   output logic          empty,
   input  wire logic     pop,
   output word_type      pop_word
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   word_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic wr_en, rd_en;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign wr_en    = push && !full;
   assign rd_en    = pop && !empty;
   assign pop_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

>>> hdl/gsc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gsc_front #(
   parameter int SAMPLES_PER_TICK = gsc_pkg::SAMPLES_PER_TICK_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire gsc_pkg::req_type  req_word,
   output logic                   req_full,
   output logic                   sums_push,
   output gsc_pkg::sums_type      sums_word,
   input  wire logic              sums_full
);
   import gsc_pkg::*;

   localparam int IDX_W = (SAMPLES_PER_TICK > 1) ? $clog2(SAMPLES_PER_TICK) : 1;

   logic [IDX_W-1:0] index_ff, index_in;
   sums_type         sum_ff, sum_in;
   sums_type         total;
   logic [RATE_W-1:0] rate [NUM_AXES];
   logic accept, last;

   assign rate[0] = req_word.rate_x;
   assign rate[1] = req_word.rate_y;
   assign rate[2] = req_word.rate_z;

   assign req_full  = sums_full;
   assign accept    = req_push && !sums_full;
   assign last      = (index_ff == IDX_W'(SAMPLES_PER_TICK - 1));
   assign sums_push = accept && last;
   assign sums_word = total;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         total[a] = sum_ff[a] + {{(SUM_W - RATE_W){rate[a][RATE_W-1]}}, rate[a]};
      end
      sum_in   = sum_ff;
      index_in = index_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            index_in = '0;
         end else begin
            sum_in   = total;
            index_in = index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         sum_ff   <= '0;
      end else begin
         index_ff <= index_in;
         sum_ff   <= sum_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/gsc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gsc_back #(
   parameter int SAMPLES_PER_TICK = gsc_pkg::SAMPLES_PER_TICK_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gsc_pkg::cfg_type  cfg,
   input  wire logic              sums_empty,
   output logic                   sums_pop,
   input  wire gsc_pkg::sums_type sums_word,
   output logic                   rsp_push,
   output gsc_pkg::rsp_type       rsp_word,
   input  wire logic              rsp_full
);
   import gsc_pkg::*;

   // |sum| < 2^19; reciprocal scaled so truncation is exact over that range
   localparam int MAG_W   = SUM_W - 1;
   localparam int SHIFT   = MAG_W + 5;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_C =
      RECIP_W'(((64'd1 << SHIFT) + SAMPLES_PER_TICK - 1) / SAMPLES_PER_TICK);
   localparam int CHG_W   = AVG_W + 1;

   function automatic axis_type strict_max(input logic [CHG_W-1:0] v0,
                                           input logic [CHG_W-1:0] v1,
                                           input logic [CHG_W-1:0] v2);
      axis_type r;
      if (v0 > v1 && v0 > v2) begin
         r = AXIS_X;
      end else if (v1 > v0 && v1 > v2) begin
         r = AXIS_Y;
      end else if (v2 > v0 && v2 > v1) begin
         r = AXIS_Z;
      end else begin
         r = AXIS_NONE;
      end
      return r;
   endfunction

   logic en, tick_fire, decide, added, close;

   // stage 1: magnitude times reciprocal
   logic              prod_valid_ff;
   logic [PROD_W-1:0] prod_ff [NUM_AXES];
   logic [PROD_W-1:0] prod_in [NUM_AXES];
   logic              neg_ff  [NUM_AXES];
   logic              neg_in  [NUM_AXES];
   logic [SUM_W-1:0]  mag_full [NUM_AXES];

   // stage 2: signed average
   logic                    avg_valid_ff;
   logic signed [AVG_W-1:0] avg_ff [NUM_AXES];
   logic signed [AVG_W-1:0] avg_in [NUM_AXES];
   logic [CHG_W-1:0]        quot   [NUM_AXES];
   logic [CHG_W-1:0]        sres   [NUM_AXES];

   // tick state
   logic signed [AVG_W-1:0] cur_ff [NUM_AXES];
   logic signed [AVG_W-1:0] cur_in [NUM_AXES];
   logic signed [AVG_W-1:0] hi_ff  [NUM_AXES];
   logic signed [AVG_W-1:0] hi_in  [NUM_AXES];
   logic signed [AVG_W-1:0] lo_ff  [NUM_AXES];
   logic signed [AVG_W-1:0] lo_in  [NUM_AXES];
   logic [WEIGHT_W-1:0]     weight_ff [NUM_AXES];
   logic [WEIGHT_W-1:0]     weight_in [NUM_AXES];
   logic [WEIGHT_W-1:0]     weight_base [NUM_AXES];
   logic [COUNT_W-1:0]      period_ff, period_in, period_inc;
   axis_type                chosen_ff, chosen_in, winner;
   logic signed [CHG_W-1:0] diff   [NUM_AXES];
   logic [CHG_W-1:0]        change [NUM_AXES];
   logic [CHG_W-1:0]        chg    [NUM_AXES];
   logic                    take   [NUM_AXES];

   // stage 3: snapshot after the tick update
   logic                    snap_valid_ff;
   logic signed [AVG_W-1:0] snap_prev_ff [NUM_AXES];
   logic signed [AVG_W-1:0] snap_cur_ff  [NUM_AXES];
   logic signed [AVG_W-1:0] snap_hi_ff   [NUM_AXES];
   logic signed [AVG_W-1:0] snap_lo_ff   [NUM_AXES];
   axis_type                snap_axis_ff;

   // stage 4: midpoint crossing
   logic                    cross_valid_ff;
   logic                    cross_ff, cross_in;
   axis_type                out_axis_ff;
   logic signed [AVG_W-1:0] sel_p, sel_c, sel_h, sel_l;
   logic                    has_axis;
   logic signed [CHG_W-1:0] mid_sum, mid_adj, mid, p17, c17;

   // window and step total
   logic [COUNT_W-1:0] window_ff, window_in, window_inc;
   logic               wcross_ff, wcross_in, wcross_any;
   logic [STEPS_W-1:0] steps_ff, steps_in;

   assign en        = !rsp_full;
   assign sums_pop  = en && !sums_empty;
   assign tick_fire = en && avg_valid_ff;
   assign rsp_push  = en && cross_valid_ff;

   // stage 1
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         neg_in[a]   = sums_word[a][SUM_W-1];
         mag_full[a] = neg_in[a] ? (SUM_W'(0) - sums_word[a]) : sums_word[a];
         prod_in[a]  = PROD_W'(mag_full[a][MAG_W-1:0]) * PROD_W'(RECIP_C);
      end
   end

   // stage 2
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         quot[a]   = prod_ff[a][SHIFT +: CHG_W];
         sres[a]   = neg_ff[a] ? (CHG_W'(0) - quot[a]) : quot[a];
         avg_in[a] = sres[a][AVG_W-1:0];
      end
   end

   // tick update
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         diff[a]   = {avg_ff[a][AVG_W-1], avg_ff[a]} - {cur_ff[a][AVG_W-1], cur_ff[a]};
         change[a] = diff[a][CHG_W-1] ? CHG_W'(-diff[a]) : CHG_W'(diff[a]);
         take[a]   = !(change[a] < {1'b0, cfg.min_change} ||
                       change[a] > {1'b0, cfg.max_change});
         cur_in[a] = take[a] ? avg_ff[a] : cur_ff[a];
         // change against the last accepted value is zero when rejected
         chg[a]    = take[a] ? change[a] : '0;
         hi_in[a]  = (cur_in[a] > hi_ff[a]) ? cur_in[a] : hi_ff[a];
         lo_in[a]  = (cur_in[a] < lo_ff[a]) ? cur_in[a] : lo_ff[a];
      end

      period_inc = period_ff + 1'b1;
      decide     = (period_inc >= cfg.axis_period);
      if (decide) begin
         chosen_in = strict_max(CHG_W'(weight_ff[0]), CHG_W'(weight_ff[1]),
                                CHG_W'(weight_ff[2]));
         period_in = '0;
      end else begin
         chosen_in = chosen_ff;
         period_in = period_inc;
      end

      winner = strict_max(chg[0], chg[1], chg[2]);
      for (int a = 0; a < NUM_AXES; a++) begin
         weight_base[a] = decide ? '0 : weight_ff[a];
         weight_in[a]   = weight_base[a];
         if (winner == axis_type'(2'(a + 1)) && weight_base[a] != '1) begin
            weight_in[a] = weight_base[a] + 1'b1;
         end
      end
   end

   // stage 4
   always_comb begin
      has_axis = 1'b1;
      case (snap_axis_ff)
         AXIS_X: begin
            sel_p = snap_prev_ff[0];
            sel_c = snap_cur_ff[0];
            sel_h = snap_hi_ff[0];
            sel_l = snap_lo_ff[0];
         end
         AXIS_Y: begin
            sel_p = snap_prev_ff[1];
            sel_c = snap_cur_ff[1];
            sel_h = snap_hi_ff[1];
            sel_l = snap_lo_ff[1];
         end
         AXIS_Z: begin
            sel_p = snap_prev_ff[2];
            sel_c = snap_cur_ff[2];
            sel_h = snap_hi_ff[2];
            sel_l = snap_lo_ff[2];
         end
         default: begin
            has_axis = 1'b0;
            sel_p    = '0;
            sel_c    = '0;
            sel_h    = '0;
            sel_l    = '0;
         end
      endcase
      mid_sum = {sel_h[AVG_W-1], sel_h} + {sel_l[AVG_W-1], sel_l};
      // halve toward zero
      mid_adj = mid_sum + {{(CHG_W - 1){1'b0}}, mid_sum[CHG_W-1]};
      mid     = mid_adj >>> 1;
      p17     = {sel_p[AVG_W-1], sel_p};
      c17     = {sel_c[AVG_W-1], sel_c};
      cross_in = has_axis && ((p17 < mid && c17 > mid) || (p17 > mid && c17 < mid));
   end

   // window close and result
   always_comb begin
      window_inc = window_ff + 1'b1;
      close      = (window_inc >= cfg.window_ticks);
      wcross_any = wcross_ff || cross_ff;
      added      = close && wcross_any;
      window_in  = close ? '0 : window_inc;
      wcross_in  = close ? 1'b0 : wcross_any;
      steps_in   = added ? steps_ff + 1'b1 : steps_ff;

      rsp_word.step_total    = steps_in;
      rsp_word.dominant_axis = out_axis_ff;
      rsp_word.crossed_now   = cross_ff;
      rsp_word.step_added    = added;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff  <= 1'b0;
         avg_valid_ff   <= 1'b0;
         snap_valid_ff  <= 1'b0;
         cross_valid_ff <= 1'b0;
      end else if (en) begin
         prod_valid_ff  <= !sums_empty;
         avg_valid_ff   <= prod_valid_ff;
         snap_valid_ff  <= avg_valid_ff;
         cross_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            prod_ff[a]      <= prod_in[a];
            neg_ff[a]       <= neg_in[a];
            avg_ff[a]       <= avg_in[a];
            snap_prev_ff[a] <= cur_ff[a];
            snap_cur_ff[a]  <= cur_in[a];
            snap_hi_ff[a]   <= hi_in[a];
            snap_lo_ff[a]   <= lo_in[a];
         end
         snap_axis_ff <= chosen_in;
         cross_ff     <= cross_in;
         out_axis_ff  <= snap_axis_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            cur_ff[a]    <= '0;
            hi_ff[a]     <= '0;
            lo_ff[a]     <= '0;
            weight_ff[a] <= '0;
         end
         period_ff <= '0;
         chosen_ff <= AXIS_NONE;
      end else if (tick_fire) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            cur_ff[a]    <= cur_in[a];
            hi_ff[a]     <= hi_in[a];
            lo_ff[a]     <= lo_in[a];
            weight_ff[a] <= weight_in[a];
         end
         period_ff <= period_in;
         chosen_ff <= chosen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         wcross_ff <= 1'b0;
         steps_ff  <= '0;
      end else if (rsp_push) begin
         window_ff <= window_in;
         wcross_ff <= wcross_in;
         steps_ff  <= steps_in;
      end
   end

   a_axis_held: assert property (@(posedge clock) disable iff (reset)
      !(tick_fire && decide) |=> $stable(chosen_ff))
      else $error("dominant axis changed outside a decision tick");

   a_step_inc: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && added) |=> (steps_ff == $past(steps_ff) + 16'd1))
      else $error("step total did not advance on a closed window");

   a_cross_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && cross_ff) |-> (out_axis_ff != AXIS_NONE))
      else $error("crossing reported without a dominant axis");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!en && cross_valid_ff) |=> (cross_valid_ff && $stable(cross_ff)))
      else $error("result stage moved while stalled");

endmodule
`default_nettype wire
